@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros used by the port checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define DTOI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// clocked assertion that also holds during reset
`define DTOI_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

@@ hdl/dtoi_pkg.sv @@
// ---------------------------------------------------------------------------
// dtoi_pkg
// types, constants and the limit digit table for the decimal text converter
// ---------------------------------------------------------------------------
package dtoi_pkg;

    localparam int CharW  = 8;
    localparam int ValueW = 64;
    localparam int CountW = 5;
    localparam int DigitW = 4;

    localparam logic [CountW-1:0] MaxDigits  = CountW'(19);
    localparam logic [CountW-1:0] SatDigits  = CountW'(20);
    localparam logic [CountW-1:0] LastDigIdx = CountW'(18);

    localparam logic [CharW-1:0] CharZero  = 8'h30;
    localparam logic [CharW-1:0] CharNine  = 8'h39;
    localparam logic [CharW-1:0] CharMinus = 8'h2d;

    typedef enum logic [1:0] {
        CMP_EQUAL,
        CMP_LESS,
        CMP_GREATER
    } cmp_t;

    typedef struct packed {
        logic [CharW-1:0] char_code;
        logic             has_char;
        logic             last;
    } item_t;

    typedef struct packed {
        logic signed [ValueW-1:0] value;
        logic                     status;
    } result_t;

    // take: registered request is consumed this cycle, emit: it also ends a string
    typedef struct packed {
        logic take;
        logic emit;
    } step_t;

    // digits of 9223372036854775807, final digit 8 for a negative value
    function automatic logic [DigitW-1:0] limit_digit(input logic [CountW-1:0] idx,
                                                      input logic neg);
        logic [DigitW-1:0] d;
        unique case (idx)
            5'd0:    d = 4'd9;
            5'd1:    d = 4'd2;
            5'd2:    d = 4'd2;
            5'd3:    d = 4'd3;
            5'd4:    d = 4'd3;
            5'd5:    d = 4'd7;
            5'd6:    d = 4'd2;
            5'd7:    d = 4'd0;
            5'd8:    d = 4'd3;
            5'd9:    d = 4'd6;
            5'd10:   d = 4'd8;
            5'd11:   d = 4'd5;
            5'd12:   d = 4'd4;
            5'd13:   d = 4'd7;
            5'd14:   d = 4'd7;
            5'd15:   d = 4'd5;
            5'd16:   d = 4'd8;
            5'd17:   d = 4'd0;
            LastDigIdx: d = neg ? 4'd8 : 4'd7;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

endpackage

@@ hdl/dtoi_ifs.sv @@
// ---------------------------------------------------------------------------
// dtoi channel interfaces
// valid/ready channels for characters in and converted results out
// ---------------------------------------------------------------------------
interface dtoi_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       has_char;
    logic       last;

    modport source (output valid, output char_code, output has_char, output last,
                    input ready);
    modport sink   (input valid, input char_code, input has_char, input last,
                    output ready);
endinterface

interface dtoi_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic               status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

@@ hdl/dtoi_in_reg.sv @@
// ---------------------------------------------------------------------------
// dtoi_in_reg
// input register holding one character request until the core consumes it
// ---------------------------------------------------------------------------
module dtoi_in_reg
    import dtoi_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dtoi_in_if.sink       chars,
    input  step_t         step,
    output item_t         item,
    output logic          item_valid
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign chars.ready = !valid_reg || step.take;
    assign load        = chars.valid && chars.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (step.take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.char_code <= chars.char_code;
            item_reg.has_char  <= chars.has_char;
            item_reg.last      <= chars.last;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

@@ hdl/dtoi_accum.sv @@
// ---------------------------------------------------------------------------
// dtoi_accum
// per-string state: times-ten accumulate, limit compare and final check
// ---------------------------------------------------------------------------
module dtoi_accum
    import dtoi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  step_t   step,
    output result_t res
);

    // accumulator is kept in two's complement, so a negative string builds -magnitude
    logic [ValueW-1:0] acc_reg, acc_next, acc_upd;
    logic [CountW-1:0] cnt_reg, cnt_next, cnt_upd;
    logic              neg_reg, neg_next, neg_upd;
    logic              start_reg, start_next, start_upd;
    logic              bad_reg, bad_next, bad_upd;
    cmp_t              cmp_reg, cmp_next, cmp_upd;

    logic              num_char;
    logic [CharW-1:0]  char_off;
    logic [DigitW-1:0] digit;
    logic [DigitW-1:0] lim;
    logic [ValueW-1:0] acc_x10;
    logic [ValueW-1:0] digit_ext;
    logic [ValueW-1:0] acc_step;
    logic              fail;

    assign num_char  = (item.char_code >= CharZero) && (item.char_code <= CharNine);
    assign char_off  = item.char_code - CharZero;
    assign digit     = char_off[DigitW-1:0];
    assign lim       = limit_digit(cnt_reg, neg_reg);
    assign acc_x10   = (acc_reg << 3) + (acc_reg << 1);
    assign digit_ext = ValueW'(digit);
    assign acc_step  = neg_reg ? (acc_x10 - digit_ext) : (acc_x10 + digit_ext);

    always_comb
    begin
        acc_upd   = acc_reg;
        cnt_upd   = cnt_reg;
        neg_upd   = neg_reg;
        start_upd = start_reg;
        bad_upd   = bad_reg;
        cmp_upd   = cmp_reg;
        if (item.has_char)
        begin
            start_upd = 1'b0;
            if (start_reg && (item.char_code == CharMinus))
            begin
                neg_upd = 1'b1;
            end
            else if (!num_char)
            begin
                bad_upd = 1'b1;
            end
            else
            begin
                if (cnt_reg < MaxDigits)
                begin
                    if (cmp_reg == CMP_EQUAL)
                    begin
                        if (digit < lim)
                        begin
                            cmp_upd = CMP_LESS;
                        end
                        else if (digit > lim)
                        begin
                            cmp_upd = CMP_GREATER;
                        end
                    end
                    acc_upd = acc_step;
                end
                if (cnt_reg < SatDigits)
                begin
                    cnt_upd = cnt_reg + CountW'(1);
                end
            end
        end
    end

    assign fail = bad_upd || (cnt_upd > MaxDigits)
               || ((cnt_upd == MaxDigits) && (cmp_upd == CMP_GREATER));

    assign res.value  = fail ? '0 : acc_upd;
    assign res.status = fail;

    always_comb
    begin
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        start_next = start_reg;
        bad_next   = bad_reg;
        cmp_next   = cmp_reg;
        if (step.emit)
        begin
            acc_next   = '0;
            cnt_next   = '0;
            neg_next   = 1'b0;
            start_next = 1'b1;
            bad_next   = 1'b0;
            cmp_next   = CMP_EQUAL;
        end
        else if (step.take)
        begin
            acc_next   = acc_upd;
            cnt_next   = cnt_upd;
            neg_next   = neg_upd;
            start_next = start_upd;
            bad_next   = bad_upd;
            cmp_next   = cmp_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            start_reg <= 1'b1;
            bad_reg   <= 1'b0;
            cmp_reg   <= CMP_EQUAL;
        end
        else
        begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            neg_reg   <= neg_next;
            start_reg <= start_next;
            bad_reg   <= bad_next;
            cmp_reg   <= cmp_next;
        end
    end

endmodule

@@ hdl/dtoi_out_reg.sv @@
// ---------------------------------------------------------------------------
// dtoi_out_reg
// result register feeding the output channel
// ---------------------------------------------------------------------------
module dtoi_out_reg
    import dtoi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  step_t       step,
    input  result_t     res,
    output logic        out_free,
    dtoi_out_if.source  result
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (step.emit)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.emit)
        begin
            res_reg <= res;
        end
    end

    assign result.valid  = valid_reg;
    assign result.value  = res_reg.value;
    assign result.status = res_reg.status;

endmodule

@@ hdl/decimal_text_to_int64.sv @@
// a result is registered when the core consumes the request that ends its string
// throughput: one character request per cycle while no string end waits on a stalled result,
//   set by the combinational times-ten shift-add and per-digit limit compare in the accumulator
// a stalled result blocks only a string end; plain characters keep flowing
// reset: rst_n clears all string state and both valid flags at once
// ---------------------------------------------------------------------------
// decimal_text_to_int64
// converts a decimal ASCII string, one character per request, to int64
// ---------------------------------------------------------------------------
module decimal_text_to_int64
    import dtoi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dtoi_in_if.sink     chars,
    dtoi_out_if.source  result
);

    item_t   item;
    logic    item_valid;
    logic    out_free;
    step_t   step;
    result_t res;

    // a string end may only be consumed when the result register can take it
    assign step.take = item_valid && (!item.last || out_free);
    assign step.emit = step.take && item.last;

    dtoi_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .step       (step),
        .item       (item),
        .item_valid (item_valid)
    );

    dtoi_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .step  (step),
        .res   (res)
    );

    dtoi_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .res      (res),
        .out_free (out_free),
        .result   (result)
    );

endmodule

@@ hdl/dtoi_checker.sv @@
// ---------------------------------------------------------------------------
// dtoi_port_checks
// port-level checks on the converter, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dtoi_port_checks
    import dtoi_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     in_last,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [ValueW-1:0] out_value,
    input logic                     out_status
);

    // string ends accepted but not yet delivered
    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       end_in;
    logic       end_out;

    assign end_in  = in_valid && in_ready && in_last;
    assign end_out = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (end_in && !end_out)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!end_in && end_out)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `DTOI_ASSERT(a_fail_is_zero, clk, rst_n, (out_valid && out_status) |-> (out_value == '0))
    `DTOI_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_status)))
    `DTOI_ASSERT(a_no_invented, clk, rst_n, out_valid |-> (pending_reg != 2'd0))
    `DTOI_ASSERT_ALWAYS(a_depth, clk, pending_reg !== 2'd3)

endmodule

bind decimal_text_to_int64 dtoi_port_checks u_dtoi_port_checks (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (chars.valid),
    .in_ready   (chars.ready),
    .in_last    (chars.last),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_value  (result.value),
    .out_status (result.status)
);

@@ bench/dtoi_checker.sv @@
// ---------------------------------------------------------------------------
// dtoi_checker
// watches both channels of the converter, predicts each conversion from the
// accepted characters and compares every accepted result with the oldest one
// ---------------------------------------------------------------------------
module dtoi_checker
    import dtoi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [CharW-1:0]         char_code,
    input  logic                     has_char,
    input  logic                     last,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [ValueW-1:0] value,
    input  logic                     status,
    output int                       fail_count,
    output int                       pending_count,
    output int                       result_count,
    output int                       reject_count
);

    localparam logic [ValueW-1:0] PosLimit = 64'h7fff_ffff_ffff_ffff;
    localparam logic [ValueW-1:0] NegLimit = 64'h8000_0000_0000_0000;
    localparam int                MaxPrinted = 40;

    // running state of the string being collected
    logic [ValueW-1:0] mag_acc;
    logic [CountW-1:0] digits_seen;
    logic              minus_seen;
    logic              awaiting_first;
    logic              junk_seen;

    result_t conversions_due[$];
    int      n_fail;
    int      n_results;
    int      n_rejects;

    task automatic clear_text();
        mag_acc        = '0;
        digits_seen    = '0;
        minus_seen     = 1'b0;
        awaiting_first = 1'b1;
        junk_seen      = 1'b0;
    endtask

    task automatic fold_char(input logic [CharW-1:0] c);
        logic first;
        first          = awaiting_first;
        awaiting_first = 1'b0;
        if (first && c == CharMinus)
            minus_seen = 1'b1;
        else if (c < CharZero || c > CharNine)
            junk_seen = 1'b1;
        else
        begin
            // only the first 19 digits reach the magnitude
            if (digits_seen < MaxDigits)
                mag_acc = mag_acc * 64'd10 + 64'(c - CharZero);
            if (digits_seen < SatDigits)
                digits_seen = digits_seen + 1'b1;
        end
    endtask

    function automatic result_t convert_text();
        result_t r;
        logic    out_of_range;
        // with exactly 19 digits the magnitude cannot wrap, so a plain compare works
        out_of_range = (digits_seen > MaxDigits)
                    || (digits_seen == MaxDigits
                        && mag_acc > (minus_seen ? NegLimit : PosLimit));
        r.status = junk_seen || out_of_range;
        if (r.status)
            r.value = '0;
        else
            r.value = minus_seen ? -mag_acc : mag_acc;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [ValueW-1:0] got,
                                   input logic [ValueW-1:0] want);
        if (n_fail < MaxPrinted)
            $display("mismatch on result %0d: %s got %h expected %h",
                     n_results, what, got, want);
        n_fail++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            clear_text();
            conversions_due.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (has_char)
                    fold_char(char_code);
                if (last)
                begin
                    conversions_due.push_back(convert_text());
                    clear_text();
                end
            end
            if (out_valid && out_ready)
            begin
                n_results++;
                if (status)
                    n_rejects++;
                if (conversions_due.size() == 0)
                    report_mismatch("unexpected result, value", value, '0);
                else
                begin
                    want = conversions_due.pop_front();
                    if (value !== want.value)
                        report_mismatch("value", value, want.value);
                    if (status !== want.status)
                        report_mismatch("status", 64'(status), 64'(want.status));
                end
            end
        end
        fail_count    <= n_fail;
        pending_count <= conversions_due.size();
        result_count  <= n_results;
        reject_count  <= n_rejects;
    end

endmodule

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// drives character strings into the decimal converter with random gaps and
// result stalls, including long hold-offs; dtoi_checker does the comparing
// ---------------------------------------------------------------------------
module tb_top
    import dtoi_pkg::*;
();

    localparam int ItemGoal   = 1750;
    localparam int HoldLen    = 300;
    localparam int IdleLimit  = 5000;
    localparam int TailCycles = 8;

    typedef logic [CharW-1:0] text_t[$];

    logic clk;
    logic rst_n;

    dtoi_in_if  chars_if();
    dtoi_out_if res_if();

    int    fails;
    int    pending;
    int    results;
    int    rejects;
    item_t text_q[$];
    int    n_items;
    int    n_texts;
    int    n_holds;
    bit    tx_calm;
    bit    rx_calm;
    bit    hold_req;

    decimal_text_to_int64 dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .result (res_if)
    );

    dtoi_checker conv_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (chars_if.valid),
        .in_ready      (chars_if.ready),
        .char_code     (chars_if.char_code),
        .has_char      (chars_if.has_char),
        .last          (chars_if.last),
        .out_valid     (res_if.valid),
        .out_ready     (res_if.ready),
        .value         (res_if.value),
        .status        (res_if.status),
        .fail_count    (fails),
        .pending_count (pending),
        .result_count  (results),
        .reject_count  (rejects)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pause_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic text_t digits_of(input logic [ValueW-1:0] n, input int width);
        text_t ds;
        do
        begin
            ds.push_front(CharZero + 8'(n % 10));
            n = n / 10;
        end
        while (n != 0);
        while (ds.size() < width)
            ds.push_front(CharZero);
        return ds;
    endfunction

    task automatic put(input logic [CharW-1:0] c, input logic has, input logic fin);
        item_t it;
        it.char_code = c;
        it.has_char  = has;
        it.last      = fin;
        text_q.push_back(it);
    endtask

    // now and then a bare terminator that is not last slips in before a character
    task automatic put_char(input logic [CharW-1:0] c);
        if ($urandom_range(0, 24) == 0)
            put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        put(c, 1'b1, 1'b0);
    endtask

    task automatic put_digits(input text_t ds);
        foreach (ds[i])
            put_char(ds[i]);
    endtask

    task automatic put_random_digit();
        put_char(CharZero + 8'($urandom_range(0, 9)));
    endtask

    task automatic close_text();
        item_t it;
        int    idx;
        idx = text_q.size() - 1;
        if (idx >= 0 && text_q[idx].has_char && $urandom_range(0, 1) == 1)
        begin
            it      = text_q[idx];
            it.last = 1'b1;
            text_q[idx] = it;
        end
        else
            put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic make_text();
        int                kind;
        int                len;
        int                p;
        logic              neg;
        logic [ValueW-1:0] base;
        text_t             ds;
        kind = $urandom_range(0, 99);
        neg  = ($urandom_range(0, 3) == 0);
        if (kind < 30)
        begin
            if (neg)
                put_char(CharMinus);
            if ($urandom_range(0, 1) == 1)
            begin
                len = $urandom_range(1, 8);
                repeat (len) put_random_digit();
            end
            else
                put_digits(digits_of({$urandom, $urandom} >> $urandom_range(0, 63), 0));
        end
        else if (kind < 42)
        begin
            // within a few counts of the range limit for the sign
            if (neg)
                put_char(CharMinus);
            base = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            base = base + 64'($urandom_range(0, 6)) - 64'd3;
            put_digits(digits_of(base, 19));
        end
        else if (kind < 52)
        begin
            // limit digits with one position changed and a random tail after it
            neg  = 1'($urandom_range(0, 1));
            base = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            ds   = digits_of(base, 19);
            p    = $urandom_range(0, 18);
            for (int i = p; i < 19; i++)
                if (i == p || $urandom_range(0, 1) == 1)
                    ds[i] = CharZero + 8'($urandom_range(0, 9));
            if (neg)
                put_char(CharMinus);
            put_digits(ds);
        end
        else if (kind < 60)
        begin
            if (neg)
                put_char(CharMinus);
            len = $urandom_range(17, 23);
            repeat (len) put_random_digit();
        end
        else if (kind < 67)
        begin
            if (neg)
                put_char(CharMinus);
            put_digits(digits_of(64'($urandom_range(0, 99999)), $urandom_range(1, 24)));
        end
        else if (kind < 77)
        begin
            // one stray byte (often a misplaced minus) inside a number
            len = $urandom_range(0, 6);
            p   = $urandom_range(0, len);
            if (neg)
                put_char(CharMinus);
            for (int i = 0; i <= len; i++)
                if (i != p)
                    put_random_digit();
                else if ($urandom_range(0, 3) == 0)
                    put_char(CharMinus);
                else
                    put_char(8'($urandom_range(0, 255)));
        end
        else if (kind < 85)
        begin
            // empty string or lone minus
            if (neg)
                put_char(CharMinus);
        end
        else
        begin
            len = $urandom_range(0, 6);
            repeat (len) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
        end
        close_text();
    endtask

    task automatic send_item(input item_t it);
        int gap;
        gap = 0;
        if (!tx_calm && $urandom_range(0, 2) == 0)
            gap = pause_len();
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid     <= 1'b1;
        chars_if.char_code <= it.char_code;
        chars_if.has_char  <= it.has_char;
        chars_if.last      <= it.last;
        do
            @(posedge clk);
        while (!chars_if.ready);
        if (it.has_char || it.last)
            n_items++;
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_item(text_q[i]);
        text_q.delete();
        n_texts++;
    endtask

    task automatic run_directed();
        put(8'h00, 1'b0, 1'b1);                     // terminator only
        send_text();
        put(CharMinus, 1'b1, 1'b1);                 // lone minus
        send_text();
        put(CharZero, 1'b1, 1'b1);
        send_text();
        put(CharNine, 1'b1, 1'b1);
        send_text();
        put(CharMinus, 1'b1, 1'b0);
        put(CharZero + 8'd5, 1'b1, 1'b1);
        send_text();
        put(CharZero + 8'd1, 1'b1, 1'b0);
        put(8'h78, 1'b0, 1'b0);                     // bare terminator, not last
        put(CharZero + 8'd2, 1'b1, 1'b1);
        send_text();
        put(CharZero + 8'd4, 1'b1, 1'b0);
        put(8'hff, 1'b0, 1'b1);
        send_text();
        put(8'h00, 1'b1, 1'b1);                     // nul character
        send_text();
        put(CharZero + 8'd1, 1'b1, 1'b0);
        put(CharMinus, 1'b1, 1'b0);                 // minus after a digit
        put(CharZero + 8'd2, 1'b1, 1'b1);
        send_text();
        put(CharMinus, 1'b1, 1'b0);
        put(CharMinus, 1'b1, 1'b1);
        send_text();
        put(8'hff, 1'b1, 1'b1);
        send_text();
        put(CharZero - 8'd1, 1'b1, 1'b1);
        send_text();
        put(CharNine + 8'd1, 1'b1, 1'b1);
        send_text();
        put(CharZero + 8'd7, 1'b0, 1'b1);           // code ignored without has_char
        send_text();
    endtask

    // result side: random stalls, calm stretches, and the long hold-offs
    initial
    begin
        int left;
        int cyc;
        left         = 0;
        cyc          = 0;
        rx_calm      = 1'b0;
        n_holds      = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 256 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            if (hold_req)
            begin
                res_if.ready <= 1'b0;
                repeat (HoldLen) @(posedge clk);
                hold_req = 1'b0;
                n_holds++;
            end
            else if (left > 0)
            begin
                res_if.ready <= 1'b0;
                left--;
            end
            else if (!rx_calm && $urandom_range(0, 3) == 0)
            begin
                res_if.ready <= 1'b0;
                left = pause_len() - 1;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // watchdog: too long without any request or result moving
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IdleLimit)
            begin
                $display("watchdog: %0d cycles without progress", idle);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        chars_if.valid     = 1'b0;
        chars_if.char_code = '0;
        chars_if.has_char  = 1'b0;
        chars_if.last      = 1'b0;
        hold_req           = 1'b0;
        tx_calm            = 1'b0;
        n_items            = 0;
        n_texts            = 0;
        rst_n              = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        while (n_items < ItemGoal)
        begin
            // receiver stops for a long stretch while strings keep coming
            if (n_texts == 60 || n_texts == 170)
                hold_req = 1'b1;
            tx_calm = hold_req || ($urandom_range(0, 4) == 0);
            make_text();
            send_text();
        end
        chars_if.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);

        $display("covered %0d strings, %0d characters and terminators, %0d long hold-offs",
                 n_texts, n_items, n_holds);
        $display("compared %0d conversions, %0d of them rejected, %0d mismatches",
                 results, rejects, fails);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
